>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ltsc_pkg.sv
// Types, codes and reset constants for the line track sweep controller.
package ltsc_pkg;

  localparam int POS_W   = 12;
  localparam int STEP_W  = 8;
  localparam int SPEED_W = 7;
  localparam int CNT_W   = 16;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  // Event codes
  localparam logic [OP_W-1:0] OP_LINE   = 3'd0;
  localparam logic [OP_W-1:0] OP_OBST   = 3'd1;
  localparam logic [OP_W-1:0] OP_DETECT = 3'd2;
  localparam logic [OP_W-1:0] OP_GIMBAL = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

  // Motion codes
  localparam logic [1:0] MOT_STOP  = 2'd0;
  localparam logic [1:0] MOT_FWD   = 2'd1;
  localparam logic [1:0] MOT_LEFT  = 2'd2;
  localparam logic [1:0] MOT_RIGHT = 2'd3;

  // Object sequence stages
  localparam logic [1:0] STG_IDLE   = 2'd0;
  localparam logic [1:0] STG_WAIT   = 2'd1;
  localparam logic [1:0] STG_SETTLE = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CENTER   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX      = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPIN     = 3'd5;
  localparam logic [IDX_W-1:0] REG_STOPWAIT = 3'd6;
  localparam logic [IDX_W-1:0] REG_COOLDOWN = 3'd7;

  localparam logic [CNT_W-1:0] SETTLE_MS = 16'd500;

  typedef struct packed {
    logic [POS_W-1:0]   sweep_center;
    logic [POS_W-1:0]   sweep_min;
    logic [POS_W-1:0]   sweep_max;
    logic [STEP_W-1:0]  sweep_step;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] spin_speed;
    logic [CNT_W-1:0]   stop_wait_ms;
    logic [CNT_W-1:0]   cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic               line_left;
    logic               line_right;
    logic               obstacle_seen;
    logic [1:0]         object_stage;
    logic               pan_is_locked;
    logic [POS_W-1:0]   locked_position;
    logic [POS_W-1:0]   current_position;
    logic               sweep_down;
    logic [1:0]         last_motion_code;
    logic [SPEED_W-1:0] last_speed_value;
    logic [CNT_W-1:0]   stage_countdown;
    logic [CNT_W-1:0]   cooldown_countdown;
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            left_active;
    logic            right_active;
    logic            obstacle_pin_a;
    logic            obstacle_pin_b;
  } item_t;

  typedef struct packed {
    logic               motion_valid;
    logic [1:0]         motion;
    logic [SPEED_W-1:0] speed;
    logic               pan_valid;
    logic [POS_W-1:0]   pan;
    logic               camera_fire;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    sweep_center: 12'd90,
    sweep_min:    12'd30,
    sweep_max:    12'd150,
    sweep_step:   8'd5,
    base_speed:   7'd50,
    spin_speed:   7'd40,
    stop_wait_ms: 16'd1000,
    cooldown_ms:  16'd3000
  };

  localparam state_t STATE_RESET = '{
    line_left:          1'b0,
    line_right:         1'b0,
    obstacle_seen:      1'b0,
    object_stage:       STG_IDLE,
    pan_is_locked:      1'b0,
    locked_position:    12'd90,
    current_position:   12'd90,
    sweep_down:         1'b0,
    last_motion_code:   MOT_STOP,
    last_speed_value:   7'd0,
    stage_countdown:    16'd0,
    cooldown_countdown: 16'd0
  };

endpackage

>>> rtl/ltsc_evt_if.sv
// Event channel: valid/ready with the event payload.
interface ltsc_evt_if;
  logic                       valid;
  logic                       ready;
  logic [ltsc_pkg::OP_W-1:0]  op;
  logic                       left_active;
  logic                       right_active;
  logic                       obstacle_pin_a;
  logic                       obstacle_pin_b;

  modport source (
    output valid, op, left_active, right_active, obstacle_pin_a, obstacle_pin_b,
    input  ready
  );
  modport sink (
    input  valid, op, left_active, right_active, obstacle_pin_a, obstacle_pin_b,
    output ready
  );
endinterface

>>> rtl/ltsc_rsp_if.sv
// Result channel: valid/ready with the result payload.
interface ltsc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          motion_valid;
  logic [1:0]                    motion;
  logic [ltsc_pkg::SPEED_W-1:0]  speed;
  logic                          pan_valid;
  logic [ltsc_pkg::POS_W-1:0]    pan;
  logic                          camera_fire;

  modport source (
    output valid, motion_valid, motion, speed, pan_valid, pan, camera_fire,
    input  ready
  );
  modport sink (
    input  valid, motion_valid, motion, speed, pan_valid, pan, camera_fire,
    output ready
  );
endinterface

>>> rtl/ltsc_step.sv
// Next-state and result logic for one event.
module ltsc_step (
  input  ltsc_pkg::state_t  st,
  input  ltsc_pkg::cfg_t    cfg,
  input  ltsc_pkg::item_t   item,
  output ltsc_pkg::state_t  st_next,
  output ltsc_pkg::result_t res
);

  always_comb begin
    logic                         act;
    logic                         rising;
    logic                         do_recompute;
    logic signed [13:0]           p;
    logic [ltsc_pkg::CNT_W-1:0]   stage_cnt;
    logic [1:0]                   want_m;
    logic [ltsc_pkg::SPEED_W-1:0] want_s;

    st_next      = st;
    res          = '0;
    do_recompute = 1'b0;
    act          = !item.obstacle_pin_a || !item.obstacle_pin_b;
    rising       = act && !st.obstacle_seen;
    p            = '0;
    stage_cnt    = '0;
    want_m       = ltsc_pkg::MOT_STOP;
    want_s       = '0;

    case (item.op)
      ltsc_pkg::OP_LINE: begin
        st_next.line_left  = item.left_active;
        st_next.line_right = item.right_active;
        do_recompute       = 1'b1;
      end
      ltsc_pkg::OP_OBST: begin
        st_next.obstacle_seen = act;
        if (act) begin
          st_next.pan_is_locked = 1'b0;
        end
        if (rising) begin
          // Forced stop plus pan to center
          st_next.last_motion_code = ltsc_pkg::MOT_STOP;
          st_next.last_speed_value = '0;
          res.motion_valid         = 1'b1;
          res.motion               = ltsc_pkg::MOT_STOP;
          res.speed                = '0;
          res.pan_valid            = 1'b1;
          res.pan                  = cfg.sweep_center;
        end
        do_recompute = 1'b1;
      end
      ltsc_pkg::OP_DETECT: begin
        if (!st.obstacle_seen && st.object_stage == ltsc_pkg::STG_IDLE &&
            st.cooldown_countdown == '0) begin
          st_next.object_stage     = ltsc_pkg::STG_WAIT;
          st_next.pan_is_locked    = 1'b1;
          st_next.locked_position  = st.current_position;
          st_next.stage_countdown  = cfg.stop_wait_ms;
          st_next.last_motion_code = ltsc_pkg::MOT_STOP;
          st_next.last_speed_value = '0;
          res.motion_valid         = 1'b1;
          res.motion               = ltsc_pkg::MOT_STOP;
          res.speed                = '0;
        end
      end
      ltsc_pkg::OP_GIMBAL: begin
        if (st.obstacle_seen) begin
          st_next.current_position = cfg.sweep_center;
          st_next.sweep_down       = 1'b0;
        end else if (st.object_stage != ltsc_pkg::STG_IDLE && st.pan_is_locked) begin
          st_next.current_position = st.locked_position;
        end else begin
          if (st.sweep_down) begin
            p = $signed({2'b00, st.current_position}) - $signed({6'd0, cfg.sweep_step});
          end else begin
            p = $signed({2'b00, st.current_position}) + $signed({6'd0, cfg.sweep_step});
          end
          if (p >= $signed({2'b00, cfg.sweep_max})) begin
            st_next.current_position = cfg.sweep_max;
            st_next.sweep_down       = 1'b1;
          end else if (p <= $signed({2'b00, cfg.sweep_min})) begin
            st_next.current_position = cfg.sweep_min;
            st_next.sweep_down       = 1'b0;
          end else begin
            st_next.current_position = p[ltsc_pkg::POS_W-1:0];
          end
        end
        res.pan_valid = 1'b1;
        res.pan       = st_next.current_position;
      end
      ltsc_pkg::OP_TICK: begin
        if (st.cooldown_countdown != '0) begin
          st_next.cooldown_countdown = st.cooldown_countdown - 16'd1;
        end
        if (st.object_stage != ltsc_pkg::STG_IDLE) begin
          stage_cnt = st.stage_countdown;
          if (stage_cnt != '0) begin
            stage_cnt = stage_cnt - 16'd1;
          end
          st_next.stage_countdown = stage_cnt;
          if (stage_cnt == '0) begin
            if (st.object_stage == ltsc_pkg::STG_WAIT) begin
              st_next.object_stage    = ltsc_pkg::STG_SETTLE;
              st_next.stage_countdown = ltsc_pkg::SETTLE_MS;
              res.camera_fire         = 1'b1;
            end else begin
              st_next.object_stage       = ltsc_pkg::STG_IDLE;
              st_next.pan_is_locked      = 1'b0;
              st_next.current_position   = st.locked_position;
              st_next.cooldown_countdown = cfg.cooldown_ms;
              do_recompute               = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Issue a motion command only when the wanted pair changes
    if (do_recompute) begin
      if (!st_next.obstacle_seen && st_next.object_stage == ltsc_pkg::STG_IDLE) begin
        if (!st_next.line_left && !st_next.line_right) begin
          want_m = ltsc_pkg::MOT_FWD;
          want_s = cfg.base_speed;
        end else if (st_next.line_left && !st_next.line_right) begin
          want_m = ltsc_pkg::MOT_LEFT;
          want_s = cfg.spin_speed;
        end else if (!st_next.line_left && st_next.line_right) begin
          want_m = ltsc_pkg::MOT_RIGHT;
          want_s = cfg.spin_speed;
        end
      end
      if (want_m != st_next.last_motion_code || want_s != st_next.last_speed_value) begin
        st_next.last_motion_code = want_m;
        st_next.last_speed_value = want_s;
        res.motion_valid         = 1'b1;
        res.motion               = want_m;
        res.speed                = want_s;
      end
    end
  end

endmodule

>>> rtl/line_track_sweep_controller_top.sv
// Top level of the line track sweep controller: registers, config port, result stage.
//
//   channel  direction  handshake            payload
//   evt      in         evt.valid/evt.ready  op, left_active, right_active, obstacle pins
//   rsp      out        rsp.valid/rsp.ready  motion_valid, motion, speed, pan_valid, pan,
//                                            camera_fire
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// Cycles: one event per clock while the result register is empty or drains. Its result
// appears in the result register in the cycle after the transfer; every event updates
// the single state register stage.
// Reset: synchronous rst loads the register defaults and clears state and the result
// stage; no sweep of any kind follows.
// Stalls: while rsp is held, evt takes a new transfer only when rsp drains that cycle.
module line_track_sweep_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  ltsc_evt_if.sink                      evt,
  ltsc_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [ltsc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ltsc_pkg::DATA_W-1:0]   cfg_data
);

  ltsc_pkg::cfg_t    cfg;
  ltsc_pkg::state_t  st;
  ltsc_pkg::state_t  st_next;
  ltsc_pkg::item_t   item;
  ltsc_pkg::result_t res_next;
  ltsc_pkg::result_t res;
  logic              rsp_valid;
  logic              evt_fire;

  // Take a new event whenever the result register is empty or drains now
  assign evt.ready = !rsp_valid || rsp.ready;
  assign evt_fire  = evt.valid && evt.ready;

  assign item.op             = evt.op;
  assign item.left_active    = evt.left_active;
  assign item.right_active   = evt.right_active;
  assign item.obstacle_pin_a = evt.obstacle_pin_a;
  assign item.obstacle_pin_b = evt.obstacle_pin_b;

  ltsc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Configuration registers; every index of the 3-bit field maps to a register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= ltsc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ltsc_pkg::REG_CENTER:   cfg.sweep_center <= cfg_data[ltsc_pkg::POS_W-1:0];
        ltsc_pkg::REG_MIN:      cfg.sweep_min    <= cfg_data[ltsc_pkg::POS_W-1:0];
        ltsc_pkg::REG_MAX:      cfg.sweep_max    <= cfg_data[ltsc_pkg::POS_W-1:0];
        ltsc_pkg::REG_STEP:     cfg.sweep_step   <= cfg_data[ltsc_pkg::STEP_W-1:0];
        ltsc_pkg::REG_BASE:     cfg.base_speed   <= cfg_data[ltsc_pkg::SPEED_W-1:0];
        ltsc_pkg::REG_SPIN:     cfg.spin_speed   <= cfg_data[ltsc_pkg::SPEED_W-1:0];
        ltsc_pkg::REG_STOPWAIT: cfg.stop_wait_ms <= cfg_data[ltsc_pkg::CNT_W-1:0];
        ltsc_pkg::REG_COOLDOWN: cfg.cooldown_ms  <= cfg_data[ltsc_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller state advances only on an event transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ltsc_pkg::STATE_RESET;
    end else if (evt_fire) begin
      st <= st_next;
    end
  end

  // Result stage: load on transfer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (evt_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_fire) begin
      res <= res_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.motion_valid = res.motion_valid;
  assign rsp.motion       = res.motion;
  assign rsp.speed        = res.speed;
  assign rsp.pan_valid    = res.pan_valid;
  assign rsp.pan          = res.pan;
  assign rsp.camera_fire  = res.camera_fire;

endmodule

>>> rtl/ltsc_checker.sv
// Port-level checks for the line track sweep controller, bound to the top level.
`include "assert_macros.svh"

module ltsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          evt_valid,
  input logic                          evt_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          motion_valid,
  input logic [1:0]                    motion,
  input logic [ltsc_pkg::SPEED_W-1:0]  speed,
  input logic                          pan_valid,
  input logic [ltsc_pkg::POS_W-1:0]    pan,
  input logic                          camera_fire
);

  logic        rsp_stall;
  logic [23:0] rsp_bits;
  logic        fire_out;
  logic        stop_cmd;

  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_bits  = {motion_valid, motion, speed, pan_valid, pan, camera_fire};
  assign fire_out  = rsp_valid && camera_fire;
  assign stop_cmd  = rsp_valid && motion_valid && motion == ltsc_pkg::MOT_STOP;

  `ASSERT_CLK(a_hold, clk, rst, rsp_stall |=> rsp_valid && $stable(rsp_bits), "stall moved result")
  `ASSERT_CLK(a_no_bubble, clk, rst, !rsp_stall |-> evt_ready, "event side blocked")
  `ASSERT_CLK(a_one_result, clk, rst, evt_valid && evt_ready |=> rsp_valid, "transfer gave no result")
  `ASSERT_CLK(a_fire_alone, clk, rst, fire_out |-> !motion_valid && !pan_valid, "fire not alone")
  `ASSERT_ALWAYS(a_stop_speed, clk, rst || !stop_cmd || speed == '0, "stop with nonzero speed")

endmodule

bind line_track_sweep_controller_top ltsc_checker u_ltsc_checker (
  .clk          (clk),
  .rst          (rst),
  .evt_valid    (evt.valid),
  .evt_ready    (evt.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .motion_valid (rsp.motion_valid),
  .motion       (rsp.motion),
  .speed        (rsp.speed),
  .pan_valid    (rsp.pan_valid),
  .pan          (rsp.pan),
  .camera_fire  (rsp.camera_fire)
);

>>> tb/sv/ltsc_result_checker.sv
// Checker that predicts every controller result and compares it with the result channel.
module ltsc_result_checker
  import ltsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ltsc_evt_if               evt,
  ltsc_rsp_if               rsp,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output int                mismatch_count,
  output int                pending_count
);

  // Register copy
  logic [POS_W-1:0]   center_pos;
  logic [POS_W-1:0]   sweep_lo;
  logic [POS_W-1:0]   sweep_hi;
  logic [STEP_W-1:0]  pan_step;
  logic [SPEED_W-1:0] cruise_speed;
  logic [SPEED_W-1:0] turn_speed;
  logic [CNT_W-1:0]   stop_wait;
  logic [CNT_W-1:0]   cooldown_len;

  // Controller state copy
  logic               line_l;
  logic               line_r;
  logic               obstacle_on;
  logic [1:0]         stage;
  logic               pan_locked;
  logic [POS_W-1:0]   lock_pos;
  logic [POS_W-1:0]   pan_pos;
  logic               heading_down;
  logic [1:0]         last_motion;
  logic [SPEED_W-1:0] last_speed;
  logic [CNT_W-1:0]   stage_left;
  logic [CNT_W-1:0]   cooldown_left;

  result_t expected_results[$];
  result_t want;

  function automatic void command_stop(inout result_t r);
    last_motion    = MOT_STOP;
    last_speed     = '0;
    r.motion_valid = 1'b1;
    r.motion       = MOT_STOP;
    r.speed        = '0;
  endfunction

  // Issue a drive command only when the wanted one differs from the last.
  function automatic void refresh_motion(inout result_t r);
    logic [1:0]         m;
    logic [SPEED_W-1:0] s;
    m = MOT_STOP;
    s = '0;
    if (!obstacle_on && stage == STG_IDLE) begin
      if (!line_l && !line_r) begin
        m = MOT_FWD;
        s = cruise_speed;
      end else if (line_l && !line_r) begin
        m = MOT_LEFT;
        s = turn_speed;
      end else if (!line_l && line_r) begin
        m = MOT_RIGHT;
        s = turn_speed;
      end
    end
    if (m != last_motion || s != last_speed) begin
      last_motion    = m;
      last_speed     = s;
      r.motion_valid = 1'b1;
      r.motion       = m;
      r.speed        = s;
    end
  endfunction

  function automatic result_t predict_result(input item_t ev);
    result_t r;
    int      p;
    logic    active;
    logic    rising;
    r = '0;
    case (ev.op)
      OP_LINE: begin
        line_l = ev.left_active;
        line_r = ev.right_active;
        refresh_motion(r);
      end
      OP_OBST: begin
        active      = !ev.obstacle_pin_a || !ev.obstacle_pin_b;
        rising      = active && !obstacle_on;
        obstacle_on = active;
        if (active) pan_locked = 1'b0;
        if (rising) begin
          command_stop(r);
          r.pan_valid = 1'b1;
          r.pan       = center_pos;
        end
        refresh_motion(r);
      end
      OP_DETECT: begin
        if (!obstacle_on && stage == STG_IDLE && cooldown_left == '0) begin
          stage      = STG_WAIT;
          pan_locked = 1'b1;
          lock_pos   = pan_pos;
          stage_left = stop_wait;
          command_stop(r);
        end
      end
      OP_GIMBAL: begin
        if (obstacle_on) begin
          pan_pos      = center_pos;
          heading_down = 1'b0;
        end else if (stage != STG_IDLE && pan_locked) begin
          pan_pos = lock_pos;
        end else begin
          p = heading_down ? int'(pan_pos) - int'(pan_step) : int'(pan_pos) + int'(pan_step);
          if (p >= int'(sweep_hi)) begin
            pan_pos      = sweep_hi;
            heading_down = 1'b1;
          end else if (p <= int'(sweep_lo)) begin
            pan_pos      = sweep_lo;
            heading_down = 1'b0;
          end else begin
            pan_pos = p[POS_W-1:0];
          end
        end
        r.pan_valid = 1'b1;
        r.pan       = pan_pos;
      end
      OP_TICK: begin
        if (cooldown_left != '0) cooldown_left = cooldown_left - 1'b1;
        if (stage != STG_IDLE) begin
          if (stage_left != '0) stage_left = stage_left - 1'b1;
          if (stage_left == '0) begin
            if (stage == STG_WAIT) begin
              stage         = STG_SETTLE;
              stage_left    = SETTLE_MS;
              r.camera_fire = 1'b1;
            end else begin
              stage         = STG_IDLE;
              pan_locked    = 1'b0;
              pan_pos       = lock_pos;
              cooldown_left = cooldown_len;
              refresh_motion(r);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      center_pos    = CFG_RESET.sweep_center;
      sweep_lo      = CFG_RESET.sweep_min;
      sweep_hi      = CFG_RESET.sweep_max;
      pan_step      = CFG_RESET.sweep_step;
      cruise_speed  = CFG_RESET.base_speed;
      turn_speed    = CFG_RESET.spin_speed;
      stop_wait     = CFG_RESET.stop_wait_ms;
      cooldown_len  = CFG_RESET.cooldown_ms;
      line_l        = 1'b0;
      line_r        = 1'b0;
      obstacle_on   = 1'b0;
      stage         = STG_IDLE;
      pan_locked    = 1'b0;
      lock_pos      = CFG_RESET.sweep_center;
      pan_pos       = CFG_RESET.sweep_center;
      heading_down  = 1'b0;
      last_motion   = MOT_STOP;
      last_speed    = '0;
      stage_left    = '0;
      cooldown_left = '0;
      expected_results.delete();
    end else begin
      // A result always belongs to an earlier event, so retire before predicting.
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no event outstanding");
          mismatch_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("motion_valid", 16'(want.motion_valid), 16'(rsp.motion_valid));
          check_field("motion", 16'(want.motion), 16'(rsp.motion));
          check_field("speed", 16'(want.speed), 16'(rsp.speed));
          check_field("pan_valid", 16'(want.pan_valid), 16'(rsp.pan_valid));
          check_field("pan", 16'(want.pan), 16'(rsp.pan));
          check_field("camera_fire", 16'(want.camera_fire), 16'(rsp.camera_fire));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER:   center_pos   = cfg_data[POS_W-1:0];
          REG_MIN:      sweep_lo     = cfg_data[POS_W-1:0];
          REG_MAX:      sweep_hi     = cfg_data[POS_W-1:0];
          REG_STEP:     pan_step     = cfg_data[STEP_W-1:0];
          REG_BASE:     cruise_speed = cfg_data[SPEED_W-1:0];
          REG_SPIN:     turn_speed   = cfg_data[SPEED_W-1:0];
          REG_STOPWAIT: stop_wait    = cfg_data[CNT_W-1:0];
          REG_COOLDOWN: cooldown_len = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (evt.valid && evt.ready) begin
        expected_results.insert(expected_results.size(),
                                predict_result('{op: evt.op,
                                                 left_active: evt.left_active,
                                                 right_active: evt.right_active,
                                                 obstacle_pin_a: evt.obstacle_pin_a,
                                                 obstacle_pin_b: evt.obstacle_pin_b}));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top: drives events, register writes and result back-pressure, then reports.
module tb;
  import ltsc_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  int mismatch_count;
  int pending_count;

  // Percent of cycles in which the event side holds off or the result side stalls.
  int sender_idle_pct;
  int receiver_stall_pct;

  // Shadow of the stop-wait and cooldown settings, used to size the capture runs.
  int plan_stop_wait;
  int plan_cooldown;

  ltsc_evt_if evt_ch();
  ltsc_rsp_if rsp_ch();

  line_track_sweep_controller_top uut (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ltsc_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .evt            (evt_ch),
    .rsp            (rsp_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bail out if the run hangs; even the slowest correct run ends far earlier.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Result side: decide ready afresh on every falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic item_t event_of(input logic [OP_W-1:0] op, input logic l,
                                     input logic r, input logic a, input logic b);
    item_t ev;
    ev.op             = op;
    ev.left_active    = l;
    ev.right_active   = r;
    ev.obstacle_pin_a = a;
    ev.obstacle_pin_b = b;
    return ev;
  endfunction

  // Random event with every payload bit random; op weighted toward driving events.
  function automatic item_t random_event(input bit allow_detect);
    item_t ev;
    int    pick;
    ev.left_active    = 1'($urandom_range(0, 1));
    ev.right_active   = 1'($urandom_range(0, 1));
    ev.obstacle_pin_a = 1'($urandom_range(0, 1));
    ev.obstacle_pin_b = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30)      ev.op = OP_LINE;
    else if (pick < 45) ev.op = OP_OBST;
    else if (pick < 70) ev.op = OP_GIMBAL;
    else if (pick < 90) ev.op = OP_TICK;
    else if (pick < 95) ev.op = allow_detect ? OP_DETECT : OP_TICK;
    else                ev.op = OP_W'($urandom_range(int'(OP_TICK) + 1, (1 << OP_W) - 1));
    // Release the obstacle often so the sweep and line logic get exercised.
    if (ev.op == OP_OBST && $urandom_range(0, 1) == 1) begin
      ev.obstacle_pin_a = 1'b1;
      ev.obstacle_pin_b = 1'b1;
    end
    return ev;
  endfunction

  // Enter and leave at a falling edge; hold valid until the transfer.
  task automatic send_item(input item_t ev);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid          <= 1'b1;
    evt_ch.op             <= ev.op;
    evt_ch.left_active    <= ev.left_active;
    evt_ch.right_active   <= ev.right_active;
    evt_ch.obstacle_pin_a <= ev.obstacle_pin_a;
    evt_ch.obstacle_pin_b <= ev.obstacle_pin_b;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic wait_for_results();
    evt_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DATA_W'(value);
    if (idx == REG_STOPWAIT) plan_stop_wait = value;
    if (idx == REG_COOLDOWN) plan_cooldown = value;
    @(negedge clk);
  endtask

  task automatic load_settings(input int center, input int lo, input int hi, input int step,
                               input int base, input int spin, input int stop_wait,
                               input int cooldown);
    write_reg(REG_CENTER, center);
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    write_reg(REG_STEP, step);
    write_reg(REG_BASE, base);
    write_reg(REG_SPIN, spin);
    write_reg(REG_STOPWAIT, stop_wait);
    write_reg(REG_COOLDOWN, cooldown);
    cfg_we <= 1'b0;
  endtask

  // Random driving; halfway through, pause until the controller has answered all.
  task automatic run_driving(input int count, input bit allow_detect);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_item(random_event(allow_detect));
    end
  endtask

  // Full detect, stop, capture, settle and cooldown run with driving noise in between.
  task automatic run_capture_episode();
    item_t noise;
    send_item(event_of(OP_OBST, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(event_of(OP_DETECT, 1'b0, 1'b0, 1'b1, 1'b1));
    for (int i = 0; i < plan_stop_wait + int'(SETTLE_MS); i++) begin
      // Keep noise free of ticks so the sequence ends exactly at the last tick.
      if ($urandom_range(0, 31) == 0) begin
        noise = random_event(1'b0);
        if (noise.op != OP_TICK) send_item(noise);
      end
      send_item(event_of(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1));
    end
    // A detection during cooldown must be refused; then drain the cooldown.
    if (plan_cooldown != 0) begin
      send_item(event_of(OP_DETECT, 1'b1, 1'b0, 1'b0, 1'b1));
      for (int i = 0; i < plan_cooldown; i++) begin
        send_item(event_of(OP_TICK, 1'b0, 1'b1, 1'b1, 1'b0));
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    evt_ch.valid          = 1'b0;
    evt_ch.op             = OP_LINE;
    evt_ch.left_active    = 1'b0;
    evt_ch.right_active   = 1'b0;
    evt_ch.obstacle_pin_a = 1'b1;
    evt_ch.obstacle_pin_b = 1'b1;
    sender_idle_pct       = 32;
    receiver_stall_pct    = 63;
    plan_stop_wait        = int'(CFG_RESET.stop_wait_ms);
    plan_cooldown         = int'(CFG_RESET.cooldown_ms);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Shorten the stop wait so the directed part reaches the camera fire.
    write_reg(REG_STOPWAIT, 2);
    cfg_we <= 1'b0;

    // Directed part on the reset settings apart from the stop wait.
    send_item(event_of(OP_GIMBAL, 1'b0, 1'b0, 1'b1, 1'b1)); // sweep up one step
    send_item(event_of(OP_LINE, 1'b0, 1'b0, 1'b1, 1'b1));   // first command: forward
    send_item(event_of(OP_LINE, 1'b1, 1'b0, 1'b1, 1'b1));   // turn left
    send_item(event_of(OP_LINE, 1'b0, 1'b1, 1'b1, 1'b1));   // turn right
    send_item(event_of(OP_LINE, 1'b1, 1'b1, 1'b1, 1'b1));   // both sensors: stop
    send_item(event_of(OP_LINE, 1'b0, 1'b0, 1'b1, 1'b1));   // forward again
    send_item(event_of(OP_LINE, 1'b0, 1'b0, 1'b0, 1'b0));   // unchanged: no command
    send_item(event_of(OP_OBST, 1'b0, 1'b0, 1'b1, 1'b1));   // pins idle: no obstacle
    send_item(event_of(OP_OBST, 1'b0, 1'b0, 1'b0, 1'b1));   // obstacle rising edge
    send_item(event_of(OP_GIMBAL, 1'b1, 1'b1, 1'b0, 1'b0)); // centered on obstacle
    send_item(event_of(OP_DETECT, 1'b0, 1'b0, 1'b0, 1'b0)); // refused on obstacle
    send_item(event_of(OP_OBST, 1'b1, 1'b1, 1'b1, 1'b0));   // still seen, no edge
    send_item(event_of(OP_OBST, 1'b0, 1'b0, 1'b1, 1'b1));   // released: forward
    send_item(event_of(OP_DETECT, 1'b0, 1'b0, 1'b1, 1'b1)); // accepted: forced stop
    send_item(event_of(OP_DETECT, 1'b1, 1'b0, 1'b1, 1'b1)); // refused while running
    send_item(event_of(OP_GIMBAL, 1'b0, 1'b1, 1'b1, 1'b1)); // held at locked pan
    send_item(event_of(OP_LINE, 1'b1, 1'b0, 1'b1, 1'b1));   // no command mid sequence
    send_item(event_of(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1));   // stop wait counts down
    send_item(event_of(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1));   // camera fires
    send_item(event_of(OP_OBST, 1'b0, 1'b0, 1'b1, 1'b0));   // edge mid sequence: unlock
    send_item(event_of(OP_GIMBAL, 1'b0, 1'b0, 1'b1, 1'b1)); // centered again
    send_item(event_of(OP_OBST, 1'b0, 1'b0, 1'b1, 1'b1));   // released, still stopped
    for (int c = int'(OP_TICK) + 1; c < (1 << OP_W); c++) begin
      send_item(event_of(OP_W'(c), 1'b1, 1'b1, 1'b0, 1'b0)); // unused codes
    end

    // Wide sweep, big step, cruise speed 100, shortest stop wait and a short cooldown.
    wait_for_results();
    load_settings(4095, 0, 4095, 255, 100, 0, 1, 3);
    run_capture_episode();
    run_driving(20, 1'b0);

    // Swap the idle pattern; narrow sweep, unit step, stopped cruise.
    sender_idle_pct    = 63;
    receiver_stall_pct = 32;
    wait_for_results();
    load_settings(0, 1000, 1010, 1, 0, 100, 3, 5);
    run_driving(20, 1'b1);

    // No idling; random settings, bounds may cross.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    wait_for_results();
    load_settings($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(1, 255), $urandom_range(0, 100), $urandom_range(0, 100),
                  $urandom_range(1, 8), $urandom_range(0, 10));
    run_driving(20, 1'b1);

    // Inverted bounds and the longest counts; detections may start a sequence here.
    wait_for_results();
    load_settings(2047, 4095, 0, 128, 1, 99, 65535, 65535);
    run_driving(10, 1'b1);

    // Drain and let the result stage settle before the verdict.
    wait_for_results();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
